/* rtl/asr_pkg.sv */
package asr_pkg;

    localparam int PosW  = 20;
    localparam int VelW  = 16;
    localparam int SizeW = 16;
    localparam int TsW   = 16;

    // predicted edge, edge overlap and corrected position widths
    localparam int PredW = PosW + 1;
    localparam int DiffW = PosW + 3;
    localparam int SumW  = PosW + 4;

    localparam logic [TsW-1:0] TsReset = 16'd1092;

    localparam logic AxisX = 1'b0;
    localparam logic AxisY = 1'b1;

    typedef logic signed [PosW-1:0]  t_pos;
    typedef logic signed [VelW-1:0]  t_vel;
    typedef logic        [SizeW-1:0] t_size;
    typedef logic signed [PredW-1:0] t_pred;
    typedef logic signed [DiffW-1:0] t_diff;
    typedef logic signed [SumW-1:0]  t_sum;

    typedef struct packed {
        t_pos  a_pos_x;
        t_pos  a_pos_y;
        t_vel  a_vel_x;
        t_vel  a_vel_y;
        t_size a_width;
        t_size a_height;
        t_pos  b_pos_x;
        t_pos  b_pos_y;
        t_vel  b_vel_x;
        t_vel  b_vel_y;
        t_size b_width;
        t_size b_height;
    } t_pair;

    typedef struct packed {
        t_pred a_x;
        t_pred a_y;
        t_pred b_x;
        t_pred b_y;
    } t_pred_pos;

    typedef struct packed {
        logic  hit;
        logic  axis;
        t_diff depth;
    } t_hit;

endpackage

/* rtl/aabb_swept_collision_resolve.sv */
// throughput: one request per cycle; the five-stage pipeline advances as a whole
// and freezes only while the output register is full and i_stall is high
// reset (synchronous, i_rst_n low) empties every stage and sets time_step to 1092
module aabb_swept_collision_resolve (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [asr_pkg::TsW-1:0]       i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [asr_pkg::PosW-1:0] i_a_pos_x,
    input  logic signed [asr_pkg::PosW-1:0] i_a_pos_y,
    input  logic signed [asr_pkg::VelW-1:0] i_a_vel_x,
    input  logic signed [asr_pkg::VelW-1:0] i_a_vel_y,
    input  logic [asr_pkg::SizeW-1:0]     i_a_width,
    input  logic [asr_pkg::SizeW-1:0]     i_a_height,
    input  logic signed [asr_pkg::PosW-1:0] i_b_pos_x,
    input  logic signed [asr_pkg::PosW-1:0] i_b_pos_y,
    input  logic signed [asr_pkg::VelW-1:0] i_b_vel_x,
    input  logic signed [asr_pkg::VelW-1:0] i_b_vel_y,
    input  logic [asr_pkg::SizeW-1:0]     i_b_width,
    input  logic [asr_pkg::SizeW-1:0]     i_b_height,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_collided,
    output logic                          o_resolve_axis,
    output logic signed [asr_pkg::PosW-1:0] o_new_a_pos_x,
    output logic signed [asr_pkg::PosW-1:0] o_new_a_pos_y,
    output logic signed [asr_pkg::VelW-1:0] o_new_a_vel_x,
    output logic signed [asr_pkg::VelW-1:0] o_new_a_vel_y,
    output logic signed [asr_pkg::PosW-1:0] o_new_b_pos_x,
    output logic signed [asr_pkg::PosW-1:0] o_new_b_pos_y,
    output logic signed [asr_pkg::VelW-1:0] o_new_b_vel_x,
    output logic signed [asr_pkg::VelW-1:0] o_new_b_vel_y
);

    logic [asr_pkg::TsW-1:0] r_time_step;
    logic                    w_adv;
    asr_pkg::t_pair          w_in_pair;

    logic                    w_pred_valid;
    asr_pkg::t_pair          w_pred_pair;
    asr_pkg::t_pred_pos      w_pred;

    logic                    w_ovl_valid;
    asr_pkg::t_pair          w_ovl_pair;
    asr_pkg::t_hit           w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= asr_pkg::TsReset;
        end else if (i_cfg_wr_en) begin
            r_time_step <= i_cfg_wr_data;
        end
    end

    // the whole pipe holds only when the output register cannot be emptied
    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    always_comb begin
        w_in_pair.a_pos_x  = i_a_pos_x;
        w_in_pair.a_pos_y  = i_a_pos_y;
        w_in_pair.a_vel_x  = i_a_vel_x;
        w_in_pair.a_vel_y  = i_a_vel_y;
        w_in_pair.a_width  = i_a_width;
        w_in_pair.a_height = i_a_height;
        w_in_pair.b_pos_x  = i_b_pos_x;
        w_in_pair.b_pos_y  = i_b_pos_y;
        w_in_pair.b_vel_x  = i_b_vel_x;
        w_in_pair.b_vel_y  = i_b_vel_y;
        w_in_pair.b_width  = i_b_width;
        w_in_pair.b_height = i_b_height;
    end

    asr_predict u_predict (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_valid     (i_valid),
        .i_pair      (w_in_pair),
        .i_time_step (r_time_step),
        .o_valid     (w_pred_valid),
        .o_pair      (w_pred_pair),
        .o_pred      (w_pred)
    );

    asr_overlap u_overlap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_pred_valid),
        .i_pair  (w_pred_pair),
        .i_pred  (w_pred),
        .o_valid (w_ovl_valid),
        .o_pair  (w_ovl_pair),
        .o_hit   (w_hit)
    );

    asr_resolve u_resolve (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (w_adv),
        .i_valid        (w_ovl_valid),
        .i_pair         (w_ovl_pair),
        .i_hit          (w_hit),
        .o_valid        (o_valid),
        .o_collided     (o_collided),
        .o_resolve_axis (o_resolve_axis),
        .o_new_a_pos_x  (o_new_a_pos_x),
        .o_new_a_pos_y  (o_new_a_pos_y),
        .o_new_a_vel_x  (o_new_a_vel_x),
        .o_new_a_vel_y  (o_new_a_vel_y),
        .o_new_b_pos_x  (o_new_b_pos_x),
        .o_new_b_pos_y  (o_new_b_pos_y),
        .o_new_b_vel_x  (o_new_b_vel_x),
        .o_new_b_vel_y  (o_new_b_vel_y)
    );

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output register free");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

/* rtl/asr_predict.sv */
module asr_predict (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  logic                           i_valid,
    input  asr_pkg::t_pair                 i_pair,
    input  logic [asr_pkg::TsW-1:0]        i_time_step,
    output logic                           o_valid,
    output asr_pkg::t_pair                 o_pair,
    output asr_pkg::t_pred_pos             o_pred
);

    typedef struct packed {
        asr_pkg::t_vel a_x;
        asr_pkg::t_vel a_y;
        asr_pkg::t_vel b_x;
        asr_pkg::t_vel b_y;
    } t_disp;

    // vel * time_step, shifted down by 16 bits (time_step as unsigned Q0.16) with floor rounding
    function automatic asr_pkg::t_vel step_disp(asr_pkg::t_vel v,
                                                logic [asr_pkg::TsW-1:0] ts);
        logic signed [asr_pkg::VelW+asr_pkg::TsW:0] p;
        p = v * $signed({1'b0, ts});
        return p[asr_pkg::VelW+asr_pkg::TsW-1:asr_pkg::TsW];
    endfunction

    logic               r1_valid;
    asr_pkg::t_pair     r1_pair;
    t_disp              r1_disp;
    t_disp              n1_disp;

    logic               r2_valid;
    asr_pkg::t_pair     r2_pair;
    asr_pkg::t_pred_pos r2_pred;
    asr_pkg::t_pred_pos n2_pred;

    always_comb begin
        n1_disp.a_x = step_disp(i_pair.a_vel_x, i_time_step);
        n1_disp.a_y = step_disp(i_pair.a_vel_y, i_time_step);
        n1_disp.b_x = step_disp(i_pair.b_vel_x, i_time_step);
        n1_disp.b_y = step_disp(i_pair.b_vel_y, i_time_step);
    end

    always_comb begin
        n2_pred.a_x = asr_pkg::t_pred'(r1_pair.a_pos_x) + asr_pkg::t_pred'(r1_disp.a_x);
        n2_pred.a_y = asr_pkg::t_pred'(r1_pair.a_pos_y) + asr_pkg::t_pred'(r1_disp.a_y);
        n2_pred.b_x = asr_pkg::t_pred'(r1_pair.b_pos_x) + asr_pkg::t_pred'(r1_disp.b_x);
        n2_pred.b_y = asr_pkg::t_pred'(r1_pair.b_pos_y) + asr_pkg::t_pred'(r1_disp.b_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_pair <= i_pair;
            r1_disp <= n1_disp;
            r2_pair <= r1_pair;
            r2_pred <= n2_pred;
        end
    end

    assign o_valid = r2_valid;
    assign o_pair  = r2_pair;
    assign o_pred  = r2_pred;

endmodule

/* rtl/asr_overlap.sv */
module asr_overlap (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  asr_pkg::t_pair     i_pair,
    input  asr_pkg::t_pred_pos i_pred,
    output logic               o_valid,
    output asr_pkg::t_pair     o_pair,
    output asr_pkg::t_hit      o_hit
);

    // far edge of one box minus near edge of the other, per axis
    typedef struct packed {
        asr_pkg::t_diff ab_x;
        asr_pkg::t_diff ba_x;
        asr_pkg::t_diff ab_y;
        asr_pkg::t_diff ba_y;
    } t_gaps;

    logic           r3_valid;
    asr_pkg::t_pair r3_pair;
    t_gaps          r3_gaps;
    logic           r3_sized;
    t_gaps          n3_gaps;
    logic           n3_sized;

    logic           r4_valid;
    asr_pkg::t_pair r4_pair;
    asr_pkg::t_hit  r4_hit;
    asr_pkg::t_hit  n4_hit;
    asr_pkg::t_diff w_dx;
    asr_pkg::t_diff w_dy;

    always_comb begin
        n3_gaps.ab_x = asr_pkg::t_diff'(i_pred.a_x)
                     + asr_pkg::t_diff'({1'b0, i_pair.a_width})
                     - asr_pkg::t_diff'(i_pred.b_x);
        n3_gaps.ba_x = asr_pkg::t_diff'(i_pred.b_x)
                     + asr_pkg::t_diff'({1'b0, i_pair.b_width})
                     - asr_pkg::t_diff'(i_pred.a_x);
        n3_gaps.ab_y = asr_pkg::t_diff'(i_pred.a_y)
                     + asr_pkg::t_diff'({1'b0, i_pair.a_height})
                     - asr_pkg::t_diff'(i_pred.b_y);
        n3_gaps.ba_y = asr_pkg::t_diff'(i_pred.b_y)
                     + asr_pkg::t_diff'({1'b0, i_pair.b_height})
                     - asr_pkg::t_diff'(i_pred.a_y);
        n3_sized = (i_pair.a_width != '0) && (i_pair.a_height != '0)
                && (i_pair.b_width != '0) && (i_pair.b_height != '0);
    end

    always_comb begin
        w_dx = (r3_gaps.ab_x < r3_gaps.ba_x) ? r3_gaps.ab_x : r3_gaps.ba_x;
        w_dy = (r3_gaps.ab_y < r3_gaps.ba_y) ? r3_gaps.ab_y : r3_gaps.ba_y;
        // strict overlap on both axes with all four sizes nonzero, touching edges do not count
        n4_hit.hit = r3_sized
                  && (r3_gaps.ab_x > 0) && (r3_gaps.ba_x > 0)
                  && (r3_gaps.ab_y > 0) && (r3_gaps.ba_y > 0);
        // a tie goes vertical
        if (n4_hit.hit && (w_dx < w_dy)) begin
            n4_hit.axis  = asr_pkg::AxisX;
            n4_hit.depth = w_dx;
        end else begin
            n4_hit.axis  = n4_hit.hit ? asr_pkg::AxisY : asr_pkg::AxisX;
            n4_hit.depth = w_dy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_adv) begin
            r3_valid <= i_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_pair  <= i_pair;
            r3_gaps  <= n3_gaps;
            r3_sized <= n3_sized;
            r4_pair  <= r3_pair;
            r4_hit   <= n4_hit;
        end
    end

    assign o_valid = r4_valid;
    assign o_pair  = r4_pair;
    assign o_hit   = r4_hit;

    a_depth_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4_valid && r4_hit.hit) |-> (r4_hit.depth > 0))
        else $error("resolved depth not positive");

endmodule

/* rtl/asr_resolve.sv */
module asr_resolve (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  asr_pkg::t_pair        i_pair,
    input  asr_pkg::t_hit         i_hit,
    output logic                  o_valid,
    output logic                  o_collided,
    output logic                  o_resolve_axis,
    output asr_pkg::t_pos         o_new_a_pos_x,
    output asr_pkg::t_pos         o_new_a_pos_y,
    output asr_pkg::t_vel         o_new_a_vel_x,
    output asr_pkg::t_vel         o_new_a_vel_y,
    output asr_pkg::t_pos         o_new_b_pos_x,
    output asr_pkg::t_pos         o_new_b_pos_y,
    output asr_pkg::t_vel         o_new_b_vel_x,
    output asr_pkg::t_vel         o_new_b_vel_y
);

    function automatic asr_pkg::t_pos sat_pos(asr_pkg::t_sum v);
        logic [asr_pkg::SumW-asr_pkg::PosW:0] top;
        top = v[asr_pkg::SumW-1:asr_pkg::PosW-1];
        if (top == '0 || top == '1) begin
            return v[asr_pkg::PosW-1:0];
        end else if (v[asr_pkg::SumW-1]) begin
            return {1'b1, {(asr_pkg::PosW-1){1'b0}}};
        end else begin
            return {1'b0, {(asr_pkg::PosW-1){1'b1}}};
        end
    endfunction

    // push against own motion when fwd is low, along it when fwd is high; zero velocity counts as positive
    function automatic asr_pkg::t_pos push(asr_pkg::t_pos p, asr_pkg::t_vel v,
                                           asr_pkg::t_diff d, logic fwd);
        asr_pkg::t_sum s;
        if (v[asr_pkg::VelW-1] ^ fwd) begin
            s = asr_pkg::t_sum'(p) + asr_pkg::t_sum'(d);
        end else begin
            s = asr_pkg::t_sum'(p) - asr_pkg::t_sum'(d);
        end
        return sat_pos(s);
    endfunction

    function automatic asr_pkg::t_vel neg_vel(asr_pkg::t_vel v);
        if (v == {1'b1, {(asr_pkg::VelW-1){1'b0}}}) begin
            return {1'b0, {(asr_pkg::VelW-1){1'b1}}};
        end else begin
            return -v;
        end
    endfunction

    logic          r_valid;
    logic          r_collided;
    logic          r_axis;
    asr_pkg::t_pos r_a_pos_x, r_a_pos_y, r_b_pos_x, r_b_pos_y;
    asr_pkg::t_vel r_a_vel_x, r_a_vel_y, r_b_vel_x, r_b_vel_y;
    asr_pkg::t_pos n_a_pos_x, n_a_pos_y, n_b_pos_x, n_b_pos_y;
    asr_pkg::t_vel n_a_vel_x, n_a_vel_y, n_b_vel_x, n_b_vel_y;
    logic          w_on_x;
    logic          w_on_y;

    always_comb begin
        w_on_x = i_hit.hit && (i_hit.axis == asr_pkg::AxisX);
        w_on_y = i_hit.hit && (i_hit.axis == asr_pkg::AxisY);

        n_a_pos_x = i_pair.a_pos_x;
        n_a_vel_x = i_pair.a_vel_x;
        n_b_pos_x = i_pair.b_pos_x;
        n_b_vel_x = i_pair.b_vel_x;
        n_a_pos_y = i_pair.a_pos_y;
        n_a_vel_y = i_pair.a_vel_y;
        n_b_pos_y = i_pair.b_pos_y;
        n_b_vel_y = i_pair.b_vel_y;

        if (w_on_x) begin
            n_a_pos_x = push(i_pair.a_pos_x, i_pair.a_vel_x, i_hit.depth, 1'b0);
            n_b_pos_x = push(i_pair.b_pos_x, i_pair.b_vel_x, i_hit.depth, 1'b1);
            n_a_vel_x = neg_vel(i_pair.a_vel_x);
            n_b_vel_x = neg_vel(i_pair.b_vel_x);
        end
        if (w_on_y) begin
            n_a_pos_y = push(i_pair.a_pos_y, i_pair.a_vel_y, i_hit.depth, 1'b0);
            n_b_pos_y = push(i_pair.b_pos_y, i_pair.b_vel_y, i_hit.depth, 1'b1);
            n_a_vel_y = neg_vel(i_pair.a_vel_y);
            n_b_vel_y = neg_vel(i_pair.b_vel_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_collided <= i_hit.hit;
            r_axis     <= w_on_y;
            r_a_pos_x  <= n_a_pos_x;
            r_a_pos_y  <= n_a_pos_y;
            r_a_vel_x  <= n_a_vel_x;
            r_a_vel_y  <= n_a_vel_y;
            r_b_pos_x  <= n_b_pos_x;
            r_b_pos_y  <= n_b_pos_y;
            r_b_vel_x  <= n_b_vel_x;
            r_b_vel_y  <= n_b_vel_y;
        end
    end

    assign o_valid        = r_valid;
    assign o_collided     = r_collided;
    assign o_resolve_axis = r_axis;
    assign o_new_a_pos_x  = r_a_pos_x;
    assign o_new_a_pos_y  = r_a_pos_y;
    assign o_new_a_vel_x  = r_a_vel_x;
    assign o_new_a_vel_y  = r_a_vel_y;
    assign o_new_b_pos_x  = r_b_pos_x;
    assign o_new_b_pos_y  = r_b_pos_y;
    assign o_new_b_vel_x  = r_b_vel_x;
    assign o_new_b_vel_y  = r_b_vel_y;

    a_axis_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_collided) |-> (r_axis == asr_pkg::AxisX))
        else $error("vertical axis reported without collision");

    a_hit_carried: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_adv) |=> (r_valid && (r_collided == $past(i_hit.hit))))
        else $error("collision flag lost at output stage");

endmodule

/* test/aabb_swept_collision_resolve_test.sv */
`timescale 1ns / 1ps

module aabb_swept_collision_resolve_test;

    localparam longint PosMax = 524287;
    localparam longint PosMin = -524288;
    localparam longint VelMax = 32767;
    localparam longint VelMin = -32768;
    localparam int CycleLimit = 200000;
    localparam int IdlePct = 31;
    localparam int HoldCycles = 200;

    typedef logic [asr_pkg::TsW-1:0] t_ts;

    typedef struct packed {
        logic collided;
        logic axis;
        asr_pkg::t_pos a_px;
        asr_pkg::t_pos a_py;
        asr_pkg::t_vel a_vx;
        asr_pkg::t_vel a_vy;
        asr_pkg::t_pos b_px;
        asr_pkg::t_pos b_py;
        asr_pkg::t_vel b_vx;
        asr_pkg::t_vel b_vy;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    t_ts i_cfg_wr_data = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic o_valid;
    logic i_stall = 1'b0;
    logic o_collided;
    logic o_resolve_axis;
    asr_pkg::t_pos o_new_a_pos_x, o_new_a_pos_y, o_new_b_pos_x, o_new_b_pos_y;
    asr_pkg::t_vel o_new_a_vel_x, o_new_a_vel_y, o_new_b_vel_x, o_new_b_vel_y;

    asr_pkg::t_pair cur_pair = '0;
    asr_pkg::t_pair pair_queue[$];
    t_outcome outcome_queue[$];
    t_outcome got_res, want_res;
    t_ts ts_model = asr_pkg::TsReset;
    t_ts phase_ts = asr_pkg::TsReset;
    logic in_fire = 1'b0;
    bit calm = 1'b0;
    bit squeeze_req = 1'b0;
    bit squeeze_done = 1'b0;
    int hold_left = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    aabb_swept_collision_resolve i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_a_pos_x      (cur_pair.a_pos_x),
        .i_a_pos_y      (cur_pair.a_pos_y),
        .i_a_vel_x      (cur_pair.a_vel_x),
        .i_a_vel_y      (cur_pair.a_vel_y),
        .i_a_width      (cur_pair.a_width),
        .i_a_height     (cur_pair.a_height),
        .i_b_pos_x      (cur_pair.b_pos_x),
        .i_b_pos_y      (cur_pair.b_pos_y),
        .i_b_vel_x      (cur_pair.b_vel_x),
        .i_b_vel_y      (cur_pair.b_vel_y),
        .i_b_width      (cur_pair.b_width),
        .i_b_height     (cur_pair.b_height),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_collided     (o_collided),
        .o_resolve_axis (o_resolve_axis),
        .o_new_a_pos_x  (o_new_a_pos_x),
        .o_new_a_pos_y  (o_new_a_pos_y),
        .o_new_a_vel_x  (o_new_a_vel_x),
        .o_new_a_vel_y  (o_new_a_vel_y),
        .o_new_b_pos_x  (o_new_b_pos_x),
        .o_new_b_pos_y  (o_new_b_pos_y),
        .o_new_b_vel_x  (o_new_b_vel_x),
        .o_new_b_vel_y  (o_new_b_vel_y)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // displacement over one frame, floor of vel * ts / 2^16
    function automatic longint sweep(input longint vel, input t_ts ts);
        return (vel * longint'(ts)) >>> 16;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic t_outcome resolve_pair(input asr_pkg::t_pair p, input t_ts ts);
        t_outcome r;
        longint apx, apy, avx, avy, bpx, bpy, bvx, bvy;
        longint aw, ah, bw, bh;
        longint nax, nay, nbx, nby, dx, dy;
        apx = longint'(p.a_pos_x);
        apy = longint'(p.a_pos_y);
        avx = longint'(p.a_vel_x);
        avy = longint'(p.a_vel_y);
        bpx = longint'(p.b_pos_x);
        bpy = longint'(p.b_pos_y);
        bvx = longint'(p.b_vel_x);
        bvy = longint'(p.b_vel_y);
        aw = longint'(p.a_width);
        ah = longint'(p.a_height);
        bw = longint'(p.b_width);
        bh = longint'(p.b_height);
        r.collided = 1'b0;
        r.axis = asr_pkg::AxisX;
        if (aw != 0 && ah != 0 && bw != 0 && bh != 0) begin
            nax = apx + sweep(avx, ts);
            nay = apy + sweep(avy, ts);
            nbx = bpx + sweep(bvx, ts);
            nby = bpy + sweep(bvy, ts);
            // strict compares, touching edges stay apart
            if (nax < nbx + bw && nax + aw > nbx && nay < nby + bh && nay + ah > nby) begin
                r.collided = 1'b1;
                dx = ((nax + aw) - nbx) < ((nbx + bw) - nax) ? (nax + aw) - nbx
                                                               : (nbx + bw) - nax;
                dy = ((nay + ah) - nby) < ((nby + bh) - nay) ? (nay + ah) - nby
                                                               : (nby + bh) - nay;
                if (dx < dy) begin
                    apx = avx >= 0 ? apx - dx : apx + dx;
                    bpx = bvx >= 0 ? bpx + dx : bpx - dx;
                    avx = -avx;
                    bvx = -bvx;
                end else begin
                    // equal depths go vertical
                    r.axis = asr_pkg::AxisY;
                    apy = avy >= 0 ? apy - dy : apy + dy;
                    bpy = bvy >= 0 ? bpy + dy : bpy - dy;
                    avy = -avy;
                    bvy = -bvy;
                end
            end
        end
        r.a_px = asr_pkg::t_pos'(clip(apx, PosMin, PosMax));
        r.a_py = asr_pkg::t_pos'(clip(apy, PosMin, PosMax));
        r.a_vx = asr_pkg::t_vel'(clip(avx, VelMin, VelMax));
        r.a_vy = asr_pkg::t_vel'(clip(avy, VelMin, VelMax));
        r.b_px = asr_pkg::t_pos'(clip(bpx, PosMin, PosMax));
        r.b_py = asr_pkg::t_pos'(clip(bpy, PosMin, PosMax));
        r.b_vx = asr_pkg::t_vel'(clip(bvx, VelMin, VelMax));
        r.b_vy = asr_pkg::t_vel'(clip(bvy, VelMin, VelMax));
        return r;
    endfunction

    function automatic string show(input t_outcome r);
        return $sformatf("hit=%0d axis=%0d a=(%0d,%0d v %0d,%0d) b=(%0d,%0d v %0d,%0d)",
                         r.collided, r.axis, r.a_px, r.a_py, r.a_vx, r.a_vy,
                         r.b_px, r.b_py, r.b_vx, r.b_vy);
    endfunction

    // mostly pairs aimed to overlap after the sweep, plus raw noise
    function automatic asr_pkg::t_pair rand_pair(input t_ts ts);
        asr_pkg::t_pair p;
        int kind;
        int span;
        longint off;
        kind = $urandom_range(99);
        p.a_pos_x = asr_pkg::t_pos'($urandom);
        p.a_pos_y = asr_pkg::t_pos'($urandom);
        p.b_pos_x = asr_pkg::t_pos'($urandom);
        p.b_pos_y = asr_pkg::t_pos'($urandom);
        p.a_vel_x = asr_pkg::t_vel'($urandom);
        p.a_vel_y = asr_pkg::t_vel'($urandom);
        p.b_vel_x = asr_pkg::t_vel'($urandom);
        p.b_vel_y = asr_pkg::t_vel'($urandom);
        p.a_width = asr_pkg::t_size'($urandom);
        p.a_height = asr_pkg::t_size'($urandom);
        p.b_width = asr_pkg::t_size'($urandom);
        p.b_height = asr_pkg::t_size'($urandom);
        if (kind < 15) begin
            return p;
        end
        if ($urandom_range(3) == 0) begin
            p.a_vel_x = asr_pkg::t_vel'(int'($urandom_range(0, 512)) - 256);
            p.a_vel_y = asr_pkg::t_vel'(int'($urandom_range(0, 512)) - 256);
            p.b_vel_x = asr_pkg::t_vel'(int'($urandom_range(0, 512)) - 256);
            p.b_vel_y = asr_pkg::t_vel'(int'($urandom_range(0, 512)) - 256);
        end
        if ($urandom_range(19) == 0) begin
            case ($urandom_range(3))
                0: p.a_vel_x = asr_pkg::t_vel'(VelMin);
                1: p.a_vel_y = asr_pkg::t_vel'(VelMin);
                2: p.b_vel_x = asr_pkg::t_vel'(VelMin);
                default: p.b_vel_y = asr_pkg::t_vel'(VelMin);
            endcase
        end
        span = ($urandom_range(9) == 0) ? 65535 : $urandom_range(1, 300);
        p.a_width = asr_pkg::t_size'($urandom_range(1, span));
        p.a_height = asr_pkg::t_size'($urandom_range(1, span));
        p.b_width = asr_pkg::t_size'($urandom_range(1, span));
        p.b_height = asr_pkg::t_size'($urandom_range(1, span));
        if (kind < 27) begin
            p.a_pos_x = asr_pkg::t_pos'($urandom_range(1)
                                        ? PosMax - longint'($urandom_range(0, span))
                                        : PosMin + longint'($urandom_range(0, span)));
            p.a_pos_y = asr_pkg::t_pos'($urandom_range(1)
                                        ? PosMax - longint'($urandom_range(0, span))
                                        : PosMin + longint'($urandom_range(0, span)));
        end
        // place b so that predicted edges land around a, touching included
        off = longint'($urandom_range(0, p.a_width + p.b_width + 2)) - p.b_width - 1;
        p.b_pos_x = asr_pkg::t_pos'(longint'(p.a_pos_x) + sweep(p.a_vel_x, ts)
                                    - sweep(p.b_vel_x, ts) + off);
        off = longint'($urandom_range(0, p.a_height + p.b_height + 2)) - p.b_height - 1;
        p.b_pos_y = asr_pkg::t_pos'(longint'(p.a_pos_y) + sweep(p.a_vel_y, ts)
                                    - sweep(p.b_vel_y, ts) + off);
        if (kind >= 92) begin
            case ($urandom_range(3))
                0: p.a_width = '0;
                1: p.a_height = '0;
                2: p.b_width = '0;
                default: p.b_height = '0;
            endcase
        end
        return p;
    endfunction

    task automatic add_pair(input int apx, input int apy, input int avx, input int avy,
                            input int aw, input int ah, input int bpx, input int bpy,
                            input int bvx, input int bvy, input int bw, input int bh);
        asr_pkg::t_pair p;
        p.a_pos_x = asr_pkg::t_pos'(apx);
        p.a_pos_y = asr_pkg::t_pos'(apy);
        p.a_vel_x = asr_pkg::t_vel'(avx);
        p.a_vel_y = asr_pkg::t_vel'(avy);
        p.a_width = asr_pkg::t_size'(aw);
        p.a_height = asr_pkg::t_size'(ah);
        p.b_pos_x = asr_pkg::t_pos'(bpx);
        p.b_pos_y = asr_pkg::t_pos'(bpy);
        p.b_vel_x = asr_pkg::t_vel'(bvx);
        p.b_vel_y = asr_pkg::t_vel'(bvy);
        p.b_width = asr_pkg::t_size'(bw);
        p.b_height = asr_pkg::t_size'(bh);
        pair_queue.push_back(p);
    endtask

    task automatic wait_drained();
        while (pair_queue.size() != 0 || outcome_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(input bit write_ts, input t_ts ts,
                             input int n_items, input bit no_gaps, input bit hold);
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (write_ts) begin
            @(negedge i_clk);
            i_cfg_wr_en = 1'b1;
            i_cfg_wr_data = ts;
            @(negedge i_clk);
            i_cfg_wr_en = 1'b0;
            phase_ts = ts;
        end
        calm = no_gaps;
        squeeze_req = hold;
        for (int k = 0; k < n_items; k++) begin
            pair_queue.push_back(rand_pair(phase_ts));
        end
        wait_drained();
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (in_fire) begin
            void'(pair_queue.pop_front());
        end
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_fire) begin
            i_valid <= 1'b1;
        end else if (pair_queue.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
            i_valid <= 1'b1;
            cur_pair <= pair_queue[0];
        end else begin
            i_valid <= 1'b0;
        end
    end

    // result side back-pressure, one long hold-off when asked
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (squeeze_req && !squeeze_done) begin
            i_stall <= 1'b1;
            hold_left <= HoldCycles;
            squeeze_done <= 1'b1;
        end else begin
            i_stall <= !calm && ($urandom_range(99) < IdlePct);
        end
    end

    // predict on each accepted request, check each accepted result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ts_model <= asr_pkg::TsReset;
            in_fire <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                ts_model <= i_cfg_wr_data;
            end
            in_fire <= i_valid && !o_stall;
            if (i_valid && !o_stall) begin
                outcome_queue.push_back(resolve_pair(cur_pair, ts_model));
            end
            if (o_valid && !i_stall) begin
                got_res = {o_collided, o_resolve_axis, o_new_a_pos_x, o_new_a_pos_y,
                           o_new_a_vel_x, o_new_a_vel_y, o_new_b_pos_x, o_new_b_pos_y,
                           o_new_b_vel_x, o_new_b_vel_y};
                if (outcome_queue.size() == 0) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10) begin
                        $display("unexpected result: %s", show(got_res));
                    end
                end else begin
                    want_res = outcome_queue.pop_front();
                    if (got_res !== want_res) begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < 10) begin
                            $display("mismatch at %0t\n  exp %s\n  got %s", $realtime,
                                     show(want_res), show(got_res));
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed pairs at the reset time step
        add_pair(0, 0, 0, 0, 64, 64, 48, 8, 0, 0, 64, 64);
        add_pair(0, 0, -160, -160, 64, 64, 48, 8, -160, -160, 64, 64);
        add_pair(0, 0, 32, 32, 64, 64, 8, 50, -32, -32, 64, 64);
        // equal depths
        add_pair(0, 0, 0, 0, 32, 32, 16, 16, 0, 0, 32, 32);
        add_pair(5, 5, 0, 0, 1, 1, 5, 5, 0, 0, 1, 1);
        // touching edges
        add_pair(0, 0, 0, 0, 16, 16, 16, 0, 0, 0, 16, 16);
        add_pair(0, 0, 0, 0, 16, 16, 0, 16, 0, 0, 16, 16);
        // a zero size on each box dimension
        add_pair(0, 0, 0, 0, 0, 32, 16, 16, 0, 0, 32, 32);
        add_pair(0, 0, 0, 0, 32, 0, 16, 16, 0, 0, 32, 32);
        add_pair(0, 0, 0, 0, 32, 32, 16, 16, 0, 0, 0, 32);
        add_pair(0, 0, 0, 0, 32, 32, 16, 16, 0, 0, 32, 0);
        // fast sweep into b, and far apart
        add_pair(0, 0, 32767, 0, 64, 64, 600, 0, 0, 0, 64, 64);
        add_pair(0, 0, 0, 0, 16, 16, 1000, 1000, 0, 0, 16, 16);
        // most negative velocity, bounced on the x axis and swept apart on the y axis
        add_pair(0, 0, -32768, 0, 64, 64, -600, 0, 0, 0, 64, 64);
        add_pair(0, 0, 0, -32768, 64, 64, 0, -600, 0, -32768, 64, 64);
        // position saturation both ways
        add_pair(524237, 0, 0, 0, 100, 1000, 524287, 0, 0, 0, 100, 1000);
        add_pair(-524238, 0, 0, 0, 100, 1000, -524288, 0, -1, 0, 100, 1000);
        // field extremes
        add_pair(0, 0, 32767, 32767, 65535, 65535, 0, 0, -32768, -32768, 65535, 65535);
        add_pair(524287, 524287, 32767, 32767, 65535, 65535,
                 -524288, -524288, -32768, -32768, 65535, 65535);
        add_pair(-524288, 524287, -32768, 32767, 65535, 1,
                 524287, -524288, 32767, -32768, 1, 65535);

        run_phase(1'b0, asr_pkg::TsReset, 200, 1'b0, 1'b0);
        run_phase(1'b1, 16'd0, 300, 1'b0, 1'b0);
        run_phase(1'b1, 16'hffff, 400, 1'b0, 1'b1);
        run_phase(1'b1, 16'd1, 300, 1'b1, 1'b0);
        run_phase(1'b1, t_ts'($urandom), 400, 1'b0, 1'b0);
        run_phase(1'b1, 16'h8000, 400, 1'b0, 1'b0);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (outcome_queue.size() != 0) begin
            mismatch_count = mismatch_count + 1;
        end
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/asr_pkg.sv
rtl/asr_predict.sv
rtl/asr_overlap.sv
rtl/asr_resolve.sv
rtl/aabb_swept_collision_resolve.sv
test/aabb_swept_collision_resolve_test.sv
